// ===== hw/rtl/lz_backref_byte_decompressor_macros.svh =====
// Assertion helpers for the decompressor. Both sample on clk_i and are
// switched off while rst_ni is low.
`ifndef LZ_BACKREF_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZ_BACKREF_BYTE_DECOMPRESSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LZD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzd assertion failed");

`endif

// ===== hw/rtl/lzd_pkg.sv =====
package lzd_pkg;

  localparam int unsigned HISTORY_DEPTH = 256;
  localparam int unsigned RING_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned OUT_BYTES     = 4;
  localparam int unsigned PACK_W        = $clog2(OUT_BYTES);
  localparam int unsigned CNT_W         = PACK_W + 1;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Header bits that mark a zero-filled block, and the copy flag of a token.
  localparam logic [BYTE_W-1:0] SKIP_MASK = 8'hC0;
  localparam int unsigned       COPY_BIT  = 7;

  localparam logic [LEN_W-1:0] OUT_LEN_RESET = 9'd160;
  localparam logic [LEN_W-1:0] OUT_LEN_MAX   = 9'd256;
  localparam logic [LEN_W-1:0] PROD_MAX      = 9'd511;

  // Register index, taken from paddr[2].
  localparam logic REG_OUT_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_TOKEN    = 2'd1,
    PH_LITERAL  = 2'd2,
    PH_DISTANCE = 2'd3
  } phase_e;

  typedef logic [BYTE_W-1:0] byte_t;

  // Command that loads the byte engine when a request starts a run.
  typedef struct packed {
    logic              start;
    logic              copy;
    logic [LEN_W-1:0]  len;
    byte_t             lit;
    logic [RING_AW-1:0] src;
    logic              skip;
    logic              ends;
  } start_t;

endpackage

// ===== hw/rtl/lzd_if.sv =====
interface lzd_in_if;
  logic               valid;
  logic               ready;
  lzd_pkg::byte_t     byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface lzd_out_if;
  logic                           valid;
  logic                           ready;
  lzd_pkg::byte_t                 data0;
  lzd_pkg::byte_t                 data1;
  lzd_pkg::byte_t                 data2;
  lzd_pkg::byte_t                 data3;
  logic [lzd_pkg::CNT_W-1:0]      byte_count;
  logic                           skipped_block;
  logic                           block_end;
  logic                           last;

  modport source (output valid, output data0, output data1, output data2, output data3,
                  output byte_count, output skipped_block, output block_end, output last,
                  input ready);
  modport sink (input valid, input data0, input data1, input data2, input data3,
                input byte_count, input skipped_block, input block_end, input last,
                output ready);
endinterface

// ===== hw/rtl/lz_backref_byte_decompressor.sv =====
// Byte-serial LZ77-style block decompressor.
// in_ch takes one compressed byte per request (header, token, literal or
// distance); out_ch returns results of up to four decoded bytes with
// byte_count, skipped_block, block_end and last. The APB port holds
// out_length at address 0; pready is tied high and a write takes effect at
// its access cycle. Write it only while the block is idle.
// Flow: in_ch can take a header, token or distance byte that emits nothing
// every cycle while the byte engine is idle. A byte that emits decoded bytes
// keeps in_ch stalled until the byte engine, writing them one per cycle unless
// out_ch stalls, has put the last into the 256-entry history memory; a
// back-reference first waits for the registered read of its first byte. A
// result leaves when four bytes are packed or the request's last byte is
// written: the single write port moves one byte a cycle while nothing stalls.
// Reset clears the decode state and out_length returns to 160. The history
// memory reads as zero after reset through per-entry valid bits that reset
// clears at once, so no clearing pass is needed.
// When out_ch stalls, the finished result waits in the output register and a
// new request can still be taken; the engine holds only when a further result
// is complete and the output register is still occupied.
`include "lz_backref_byte_decompressor_macros.svh"

module lz_backref_byte_decompressor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lzd_pkg::APB_AW-1:0]     paddr,
  input  logic [lzd_pkg::APB_DW-1:0]     pwdata,
  output logic [lzd_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  lzd_in_if.sink                         in_ch,
  lzd_out_if.source                      out_ch
);

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [lzd_pkg::LEN_W-1:0] out_length_q;
  logic [lzd_pkg::LEN_W-1:0] eff_len;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lzd_pkg::REG_OUT_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_length_q <= lzd_pkg::OUT_LEN_RESET;
    end else if (cfg_wr) begin
      out_length_q <= pwdata[lzd_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == lzd_pkg::REG_OUT_LENGTH) begin
      prdata = {{(lzd_pkg::APB_DW - lzd_pkg::LEN_W){1'b0}}, out_length_q};
    end else begin
      prdata = '0;
    end
  end

  // Lengths above one history window behave as a full window.
  assign eff_len = (out_length_q > lzd_pkg::OUT_LEN_MAX) ? lzd_pkg::OUT_LEN_MAX : out_length_q;

  // ---------------------------------------------------------------------
  // Decode state.
  // ---------------------------------------------------------------------
  lzd_pkg::phase_e                 phase_q, phase_d;
  logic [lzd_pkg::RUN_W-1:0]       run_q, run_d;
  logic [lzd_pkg::LEN_W-1:0]       produced_q, produced_d;
  logic [lzd_pkg::RING_AW-1:0]     wp_q;

  // Byte engine state.
  logic                            busy_q;
  logic                            copy_q;
  logic [lzd_pkg::LEN_W-1:0]       em_rem_q;
  logic [lzd_pkg::RUN_W-1:0]       rd_rem_q;
  logic [lzd_pkg::RING_AW-1:0]     src_q;
  logic                            pend_q;
  logic                            fwd_q;
  lzd_pkg::byte_t                  fwd_data_q;
  lzd_pkg::byte_t                  lit_q;
  logic                            skip_q;
  logic                            end_q;

  // History memory and its read register.
  lzd_pkg::byte_t                  ring_mem [lzd_pkg::HISTORY_DEPTH];
  logic [lzd_pkg::HISTORY_DEPTH-1:0] ring_vld_q;
  lzd_pkg::byte_t                  rd_data_q;
  logic                            rd_vld_q;

  // Result packing and output register.
  lzd_pkg::byte_t                  pack_data_q [lzd_pkg::OUT_BYTES];
  logic [lzd_pkg::PACK_W-1:0]      pack_cnt_q;
  logic                            out_valid_q;
  lzd_pkg::byte_t                  out_data_q [lzd_pkg::OUT_BYTES];
  lzd_pkg::byte_t                  out_data_d [lzd_pkg::OUT_BYTES];
  logic [lzd_pkg::CNT_W-1:0]       out_cnt_q;
  logic                            out_skip_q;
  logic                            out_end_q;
  logic                            out_last_q;

  logic                            in_acc;
  lzd_pkg::byte_t                  in_byte;
  lzd_pkg::start_t                 cmd;

  // The engine owns the memory write port, so a new request waits for it.
  assign in_ch.ready = !busy_q;
  assign in_acc      = in_ch.valid && !busy_q;
  assign in_byte     = in_ch.byte_in;

  // Bytes added to the block count by this request, and whether the run that
  // it finishes also finishes the block.
  logic [lzd_pkg::LEN_W-1:0] add_len;
  logic [lzd_pkg::LEN_W:0]   prod_sum;
  logic [lzd_pkg::LEN_W-1:0] prod_sat;
  logic                      run_done;
  logic                      blk_done;

  assign add_len  = (phase_q == lzd_pkg::PH_LITERAL) ? lzd_pkg::LEN_W'(1)
                                                     : {2'b00, run_q};
  assign prod_sum = {1'b0, produced_q} + {1'b0, add_len};
  assign prod_sat = prod_sum[lzd_pkg::LEN_W] ? lzd_pkg::PROD_MAX
                                              : prod_sum[lzd_pkg::LEN_W-1:0];
  assign run_done = (phase_q == lzd_pkg::PH_DISTANCE) ||
                    (run_q == lzd_pkg::RUN_W'(1));
  assign blk_done = run_done && (prod_sat >= eff_len);

  // Next decode phase.
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      case (phase_q)
        lzd_pkg::PH_HEADER: begin
          if ((in_byte & lzd_pkg::SKIP_MASK) == '0 && eff_len != '0) begin
            phase_d = lzd_pkg::PH_TOKEN;
          end
        end
        lzd_pkg::PH_TOKEN: begin
          if (in_byte[lzd_pkg::COPY_BIT]) begin
            phase_d = lzd_pkg::PH_DISTANCE;
          end else if (in_byte[lzd_pkg::RUN_W-1:0] != '0) begin
            phase_d = lzd_pkg::PH_LITERAL;
          end
        end
        lzd_pkg::PH_LITERAL: begin
          if (run_done) begin
            phase_d = blk_done ? lzd_pkg::PH_HEADER : lzd_pkg::PH_TOKEN;
          end
        end
        lzd_pkg::PH_DISTANCE: begin
          phase_d = blk_done ? lzd_pkg::PH_HEADER : lzd_pkg::PH_TOKEN;
        end
        default: phase_d = lzd_pkg::PH_HEADER;
      endcase
    end
  end

  // Counters and the engine command for the accepted byte.
  always_comb begin
    run_d      = run_q;
    produced_d = produced_q;
    cmd        = '0;
    if (in_acc) begin
      case (phase_q)
        lzd_pkg::PH_HEADER: begin
          produced_d = '0;
          if ((in_byte & lzd_pkg::SKIP_MASK) != '0) begin
            // Skipped block: a whole block of zeros, ending the block.
            produced_d = eff_len;
            cmd.start  = (eff_len != '0);
            cmd.len    = eff_len;
            cmd.skip   = 1'b1;
            cmd.ends   = 1'b1;
          end
        end
        lzd_pkg::PH_TOKEN: begin
          run_d = in_byte[lzd_pkg::RUN_W-1:0];
        end
        lzd_pkg::PH_LITERAL: begin
          run_d      = run_q - lzd_pkg::RUN_W'(1);
          produced_d = prod_sat;
          cmd.start  = 1'b1;
          cmd.len    = lzd_pkg::LEN_W'(1);
          cmd.lit    = in_byte;
          cmd.ends   = blk_done;
        end
        lzd_pkg::PH_DISTANCE: begin
          // A zero-length copy still closes the run but emits nothing.
          run_d      = '0;
          produced_d = prod_sat;
          cmd.start  = (run_q != '0);
          cmd.copy   = 1'b1;
          cmd.len    = {2'b00, run_q};
          cmd.src    = wp_q - in_byte;
          cmd.ends   = blk_done;
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lzd_pkg::PH_HEADER;
      run_q      <= '0;
      produced_q <= '0;
    end else begin
      phase_q    <= phase_d;
      run_q      <= run_d;
      produced_q <= produced_d;
    end
  end

  // ---------------------------------------------------------------------
  // Byte engine. Literals and zero fill need no memory read. A copy issues
  // one read per byte; the read for byte i+1 overlaps the write of byte i.
  // With distance one those two hit the same entry, so the write data is
  // forwarded into the next byte.
  // ---------------------------------------------------------------------
  logic           byte_avail;
  lzd_pkg::byte_t byte_val;
  logic           last_byte;
  logic           completes;
  logic           stall;
  logic           consume;
  logic           issue;

  assign byte_avail = busy_q && (!copy_q || pend_q);
  assign byte_val   = !copy_q ? lit_q :
                      fwd_q   ? fwd_data_q :
                      rd_vld_q ? rd_data_q : '0;
  assign last_byte  = (em_rem_q == lzd_pkg::LEN_W'(1));
  assign completes  = (pack_cnt_q == lzd_pkg::PACK_W'(lzd_pkg::OUT_BYTES - 1)) || last_byte;
  assign stall      = completes && out_valid_q && !out_ch.ready;
  assign consume    = byte_avail && !stall;
  assign issue      = busy_q && copy_q && (rd_rem_q != '0) && (!pend_q || consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      copy_q   <= 1'b0;
      em_rem_q <= '0;
      rd_rem_q <= '0;
      pend_q   <= 1'b0;
      fwd_q    <= 1'b0;
      wp_q     <= '0;
    end else if (cmd.start) begin
      busy_q   <= 1'b1;
      copy_q   <= cmd.copy;
      em_rem_q <= cmd.len;
      rd_rem_q <= cmd.copy ? cmd.len[lzd_pkg::RUN_W-1:0] : '0;
      pend_q   <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (consume) begin
        em_rem_q <= em_rem_q - lzd_pkg::LEN_W'(1);
        wp_q     <= wp_q + lzd_pkg::RING_AW'(1);
        if (last_byte) begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        rd_rem_q <= rd_rem_q - lzd_pkg::RUN_W'(1);
        pend_q   <= 1'b1;
        fwd_q    <= consume && (wp_q == src_q);
      end else if (consume) begin
        pend_q <= 1'b0;
        fwd_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.start) begin
      src_q  <= cmd.src;
      lit_q  <= cmd.lit;
      skip_q <= cmd.skip;
      end_q  <= cmd.ends;
    end else if (issue) begin
      src_q      <= src_q + lzd_pkg::RING_AW'(1);
      fwd_data_q <= byte_val;
    end
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (consume) begin
      ring_mem[wp_q] <= byte_val;
    end
    if (issue) begin
      rd_data_q <= ring_mem[src_q];
      rd_vld_q  <= ring_vld_q[src_q];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
    end else if (consume) begin
      ring_vld_q[wp_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Packing into results. A result leaves when it holds four bytes or when
  // the request's last byte arrives; unused data slots are zero.
  // ---------------------------------------------------------------------
  logic [lzd_pkg::CNT_W-1:0] cnt_new;

  assign cnt_new = {1'b0, pack_cnt_q} + lzd_pkg::CNT_W'(1);

  always_comb begin
    for (int j = 0; j < lzd_pkg::OUT_BYTES; j++) begin
      if (lzd_pkg::CNT_W'(j) >= cnt_new) begin
        out_data_d[j] = '0;
      end else if (lzd_pkg::PACK_W'(j) == pack_cnt_q) begin
        out_data_d[j] = byte_val;
      end else begin
        out_data_d[j] = pack_data_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (consume) begin
        pack_cnt_q <= completes ? '0 : pack_cnt_q + lzd_pkg::PACK_W'(1);
      end
      if (consume && completes) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      if (completes) begin
        out_data_q <= out_data_d;
        out_cnt_q  <= cnt_new;
        out_skip_q <= skip_q;
        out_end_q  <= end_q && last_byte;
        out_last_q <= last_byte;
      end else begin
        pack_data_q[pack_cnt_q] <= byte_val;
      end
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.data0         = out_data_q[0];
  assign out_ch.data1         = out_data_q[1];
  assign out_ch.data2         = out_data_q[2];
  assign out_ch.data3         = out_data_q[3];
  assign out_ch.byte_count    = out_cnt_q;
  assign out_ch.skipped_block = out_skip_q;
  assign out_ch.block_end     = out_end_q;
  assign out_ch.last          = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // Every request flushes its partial result before the engine goes idle.
  `LZD_ASSERT_IMPLIES(a_flush_on_idle, $fell(busy_q), pack_cnt_q == '0)
  // A pending memory read only exists during a copy.
  `LZD_ASSERT_IMPLIES(a_read_in_copy, pend_q, busy_q && copy_q)
  // The end of a block is always the last result of its request.
  `LZD_ASSERT_IMPLIES(a_end_is_last, out_valid_q && out_end_q, out_last_q)
  // A literal byte always starts the engine without a memory read.
  `LZD_ASSERT_NEXT(a_literal_starts, in_acc && (phase_q == lzd_pkg::PH_LITERAL),
                   busy_q && !copy_q)

endmodule
